FILE: sv/mur3_pkg.sv
// Shared types, constants and helper functions for the streamed MurmurHash3 block.
// Depends on nothing; every other file refers to it by scoped names.
package mur3_pkg;

    localparam logic [31:0] SEED_RESET = 32'd12600123;
    localparam logic [31:0] MUL_C1     = 32'hcc9e2d51;
    localparam logic [31:0] MUL_C2     = 32'h1b873593;
    localparam logic [31:0] ADD_N      = 32'he6546b64;
    localparam logic [31:0] FIN_M1     = 32'h85ebca6b;
    localparam logic [31:0] FIN_M2     = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_TAIL,
        KIND_FULL
    } chunk_kind_t;

    typedef struct packed {
        logic [31:0] scr;
        chunk_kind_t kind;
        logic [2:0]  nbytes;
        logic        last;
    } q_entry_t;

    typedef struct packed {
        logic full;
    } q_push_t;

    function automatic logic [31:0] rotl32(input logic [31:0] v, input logic [4:0] r);
        rotl32 = (v << r) | (v >> (6'd32 - {1'b0, r}));
    endfunction

endpackage

FILE: sv/murmur3_32_stream_hash.sv
// Top level of the streamed MurmurHash3 x86_32 block.
// Instantiates mur3_front, mur3_queue and mur3_back; uses mur3_pkg.
//
// The block takes one 32-bit key chunk per cycle unless in_stall holds it, and gives one hash
// for each chunk marked last. The key is hashed as a MurmurHash3 x86_32 key with the seed
// register as its initial value. The running-hash update in the back part is a loop on
// run_reg, and that loop sets the sustained rate of one chunk per cycle when nothing stalls.
// A hash passes two front multiply stages, the queue, and three finaliser stages ahead of
// the output register. Writing the seed abandons any key in progress; the user must make a
// write only while the block is idle, and the block itself does not enforce this.
module murmur3_32_stream_hash #(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [31:0] chunk,
    input  logic [2:0]  chunk_bytes,
    input  logic        last,
    input  logic        in_valid,
    output logic        in_stall,
    output logic [31:0] hash,
    output logic        out_valid,
    input  logic        out_stall,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    mur3_pkg::q_entry_t push_entry;
    mur3_pkg::q_entry_t head;
    mur3_pkg::q_push_t  q_status;
    logic               push_valid;
    logic               head_valid;
    logic               pop;

    mur3_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk       (chunk),
        .chunk_bytes (chunk_bytes),
        .last        (last),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .push_entry  (push_entry),
        .q_status_in (q_status),
        .push_valid  (push_valid)
    );

    mur3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_entry (push_entry),
        .push_valid (push_valid),
        .q_status   (q_status),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    mur3_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .hash       (hash),
        .out_valid  (out_valid),
        .out_stall  (out_stall)
    );

endmodule

FILE: sv/mur3_front.sv
// Front part: accepts key chunks, classifies them and scrambles the key word.
// Two registered multiply stages feed the queue; uses mur3_pkg.
module mur3_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [31:0]        chunk,
    input  logic [2:0]         chunk_bytes,
    input  logic               last,
    input  logic               in_valid,
    output logic               in_stall,
    output mur3_pkg::q_entry_t push_entry,
    input  mur3_pkg::q_push_t  q_status_in,
    output logic               push_valid
);

    logic                  a_v_reg, a_v_next;
    logic [31:0]           a_prod_reg;
    mur3_pkg::chunk_kind_t a_kind_reg;
    logic [2:0]            a_nb_reg;
    logic                  a_last_reg;

    logic                  b_v_reg, b_v_next;
    logic [31:0]           b_scr_reg;
    mur3_pkg::chunk_kind_t b_kind_reg;
    logic [2:0]            b_nb_reg;
    logic                  b_last_reg;

    logic                  a_ready;
    logic                  b_ready;
    logic [2:0]            eff_nb;
    logic [31:0]           masked;
    mur3_pkg::chunk_kind_t kind;

    assign b_ready  = !b_v_reg || !q_status_in.full;
    assign a_ready  = !a_v_reg || b_ready;
    assign in_stall = !a_ready;

    always_comb
    begin
        if (!last || chunk_bytes > 3'd4)
        begin
            eff_nb = 3'd4;
        end
        else
        begin
            eff_nb = chunk_bytes;
        end
        case (eff_nb)
            3'd0:
            begin
                kind   = mur3_pkg::KIND_NONE;
                masked = 32'h0;
            end
            3'd1:
            begin
                kind   = mur3_pkg::KIND_TAIL;
                masked = chunk & 32'h0000_00ff;
            end
            3'd2:
            begin
                kind   = mur3_pkg::KIND_TAIL;
                masked = chunk & 32'h0000_ffff;
            end
            3'd3:
            begin
                kind   = mur3_pkg::KIND_TAIL;
                masked = chunk & 32'h00ff_ffff;
            end
            default:
            begin
                kind   = mur3_pkg::KIND_FULL;
                masked = chunk;
            end
        endcase
    end

    always_comb
    begin
        a_v_next = a_v_reg;
        b_v_next = b_v_reg;
        if (a_ready)
        begin
            a_v_next = in_valid;
        end
        if (b_ready)
        begin
            b_v_next = a_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
        end
        else
        begin
            a_v_reg <= a_v_next;
            b_v_reg <= b_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready)
        begin
            a_prod_reg <= masked * mur3_pkg::MUL_C1;
            a_kind_reg <= kind;
            a_nb_reg   <= eff_nb;
            a_last_reg <= last;
        end
        if (b_ready)
        begin
            b_scr_reg  <= mur3_pkg::rotl32(a_prod_reg, 5'd15) * mur3_pkg::MUL_C2;
            b_kind_reg <= a_kind_reg;
            b_nb_reg   <= a_nb_reg;
            b_last_reg <= a_last_reg;
        end
    end

    assign push_valid        = b_v_reg && !q_status_in.full;
    assign push_entry.scr    = b_scr_reg;
    assign push_entry.kind   = b_kind_reg;
    assign push_entry.nbytes = b_nb_reg;
    assign push_entry.last   = b_last_reg;

endmodule

FILE: sv/mur3_queue.sv
// Short register queue between the front and back parts.
// Holds scrambled chunk entries of type mur3_pkg::q_entry_t.
module mur3_queue #(
    parameter int DEPTH = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  mur3_pkg::q_entry_t push_entry,
    input  logic               push_valid,
    output mur3_pkg::q_push_t  q_status,
    output mur3_pkg::q_entry_t head,
    output logic               head_valid,
    input  logic               pop
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    mur3_pkg::q_entry_t slots_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_pop;

    assign head_valid    = count_reg != '0;
    assign head          = slots_reg[rd_ptr_reg];
    assign do_pop        = pop && head_valid;
    assign q_status.full = count_reg == CW'(DEPTH);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_valid)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push_valid && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push_valid && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: sv/mur3_back.sv
// Back part: running hash and length update, seed register and fmix32 finaliser.
// Takes entries from mur3_queue and drives the hash output; uses mur3_pkg.
module mur3_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  mur3_pkg::q_entry_t head,
    input  logic               head_valid,
    output logic               pop,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [31:0]        cfg_data,
    output logic [31:0]        hash,
    output logic               out_valid,
    input  logic               out_stall
);

    logic [31:0] seed_reg, seed_next;
    logic [31:0] run_reg, run_next;
    logic [31:0] len_reg, len_next;
    logic        f1_v_reg, f1_v_next;
    logic        f2_v_reg, f2_v_next;
    logic        f3_v_reg, f3_v_next;
    logic        out_v_reg, out_v_next;
    logic [31:0] f1_x_reg;
    logic [31:0] f2_x_reg;
    logic [31:0] f3_x_reg;
    logic [31:0] out_x_reg;

    logic        f1_ready, f2_ready, f3_ready, out_ready;
    logic [31:0] h_mix;
    logic [31:0] h_rot;
    logic [31:0] len_sum;
    logic [31:0] f1_sh;
    logic [31:0] f2_sh;
    logic        cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    assign out_ready = !out_v_reg || !out_stall;
    assign f3_ready  = !f3_v_reg || out_ready;
    assign f2_ready  = !f2_v_reg || f3_ready;
    assign f1_ready  = !f1_v_reg || f2_ready;
    assign pop       = head_valid && (!head.last || f1_ready);

    assign h_rot   = mur3_pkg::rotl32(run_reg ^ head.scr, 5'd13);
    assign len_sum = len_reg + {29'd0, head.nbytes};
    assign f1_sh   = f1_x_reg ^ (f1_x_reg >> 16);
    assign f2_sh   = f2_x_reg ^ (f2_x_reg >> 13);

    always_comb
    begin
        case (head.kind)
            mur3_pkg::KIND_FULL: h_mix = (h_rot << 2) + h_rot + mur3_pkg::ADD_N;
            mur3_pkg::KIND_TAIL: h_mix = run_reg ^ head.scr;
            default:             h_mix = run_reg;
        endcase
    end

    always_comb
    begin
        seed_next  = seed_reg;
        run_next   = run_reg;
        len_next   = len_reg;
        f1_v_next  = f1_v_reg;
        f2_v_next  = f2_v_reg;
        f3_v_next  = f3_v_reg;
        out_v_next = out_v_reg;
        if (cfg_write)
        begin
            seed_next = cfg_data;
            run_next  = cfg_data;
            len_next  = 32'd0;
        end
        else if (pop)
        begin
            if (head.last)
            begin
                run_next = seed_reg;
                len_next = 32'd0;
            end
            else
            begin
                run_next = h_mix;
                len_next = len_sum;
            end
        end
        if (f1_ready)
        begin
            f1_v_next = pop && head.last;
        end
        if (f2_ready)
        begin
            f2_v_next = f1_v_reg;
        end
        if (f3_ready)
        begin
            f3_v_next = f2_v_reg;
        end
        if (out_ready)
        begin
            out_v_next = f3_v_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= mur3_pkg::SEED_RESET;
            run_reg   <= mur3_pkg::SEED_RESET;
            len_reg   <= 32'd0;
            f1_v_reg  <= 1'b0;
            f2_v_reg  <= 1'b0;
            f3_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            seed_reg  <= seed_next;
            run_reg   <= run_next;
            len_reg   <= len_next;
            f1_v_reg  <= f1_v_next;
            f2_v_reg  <= f2_v_next;
            f3_v_reg  <= f3_v_next;
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f1_ready)
        begin
            f1_x_reg <= h_mix ^ len_sum;
        end
        if (f2_ready)
        begin
            f2_x_reg <= f1_sh * mur3_pkg::FIN_M1;
        end
        if (f3_ready)
        begin
            f3_x_reg <= f2_sh * mur3_pkg::FIN_M2;
        end
        if (out_ready)
        begin
            out_x_reg <= f3_x_reg ^ (f3_x_reg >> 16);
        end
    end

    assign hash      = out_x_reg;
    assign out_valid = out_v_reg;

endmodule

FILE: bench/tb.sv
// Self-checking testbench for murmur3_32_stream_hash, the streamed MurmurHash3 x86_32 block.
// Directed keys and random chunk streams are fed under random idling, and each hash is checked against
// a predictor kept in this file; it depends only on mur3_pkg and the block itself.
module tb;

    localparam int QUIET_CYCLES = 12;
    localparam int LONG_HOLD    = 100;
    localparam int RANDOM_ITEMS = 1900;
    localparam int N_PHASES     = 6;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [31:0] chunk = '0;
    logic [2:0]  chunk_bytes = '0;
    logic        last = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] hash;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [31:0] cfg_data = '0;

    logic [31:0] hash_expect[$];
    logic [31:0] seed_reg = mur3_pkg::SEED_RESET;
    logic [31:0] run_hash = mur3_pkg::SEED_RESET;
    logic [31:0] key_len = '0;
    int          err_count = 0;
    int          items_sent = 0;
    int          burst_left = 0;
    bit          no_gaps = 1'b0;
    bit          long_hold = 1'b0;
    int          hold_count = 0;
    int          rx_mode = 0;
    int          rx_cycle = 0;

    murmur3_32_stream_hash dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .chunk       (chunk),
        .chunk_bytes (chunk_bytes),
        .last        (last),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .hash        (hash),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int r);
        return (v << r) | (v >> (32 - r));
    endfunction

    function automatic logic [31:0] scramble_word(input logic [31:0] k);
        logic [31:0] t;
        t = k * mur3_pkg::MUL_C1;
        t = rol32(t, 15);
        return t * mur3_pkg::MUL_C2;
    endfunction

    function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = rol32(h ^ scramble_word(k), 13);
        return t * 32'd5 + mur3_pkg::ADD_N;
    endfunction

    function automatic logic [31:0] fmix_hash(input logic [31:0] h, input logic [31:0] len);
        logic [31:0] t;
        t = h ^ len;
        t = t ^ (t >> 16);
        t = t * mur3_pkg::FIN_M1;
        t = t ^ (t >> 13);
        t = t * mur3_pkg::FIN_M2;
        return t ^ (t >> 16);
    endfunction

    task automatic predict_chunk(input logic [31:0] c, input logic [2:0] nb, input logic lst);
        logic [31:0] h;
        logic [2:0]  n;
        logic [31:0] mask;
        if (!lst)
        begin
            run_hash = mix_word(run_hash, c);
            key_len  = key_len + 32'd4;
        end
        else
        begin
            n = (nb > 3'd4) ? 3'd4 : nb;
            h = run_hash;
            if (n == 3'd4)
            begin
                h = mix_word(h, c);
            end
            else if (n != 3'd0)
            begin
                mask = (32'd1 << (8 * n)) - 32'd1;
                h = h ^ scramble_word(c & mask);
            end
            key_len = key_len + {29'd0, n};
            hash_expect.push_back(fmix_hash(h, key_len));
            run_hash = seed_reg;
            key_len  = '0;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %08h expected %08h", $realtime, what, got, want);
        err_count++;
    endtask

    // The sender keeps valid high between transfers of a burst and drops it only for a gap.
    task automatic send_chunk(input logic [31:0] c, input logic [2:0] nb, input logic lst);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0 || no_gaps) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        chunk       <= c;
        chunk_bytes <= nb;
        last        <= lst;
        in_valid    <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predict_chunk(c, nb, lst);
        items_sent++;
    endtask

    task automatic wait_quiet();
        in_valid   <= 1'b0;
        burst_left = 0;
        while (hash_expect.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] v);
        wait_quiet();
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        seed_reg = v;
        run_hash = v;
        key_len  = '0;
    endtask

    task automatic send_random_key(input int nchunks);
        logic [2:0] nb;
        for (int i = 0; i < nchunks; i++)
        begin
            nb = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
            send_chunk($urandom, nb, 1'b0);
        end
        send_chunk($urandom, 3'($urandom_range(0, 7)), 1'b1);
    endtask

    task automatic test_directed_keys();
        send_chunk(32'h0, 3'd0, 1'b1);
        send_chunk(32'hffffffff, 3'd1, 1'b1);
        send_chunk(32'hffffffff, 3'd2, 1'b1);
        send_chunk(32'hffffffff, 3'd3, 1'b1);
        send_chunk(32'h00000000, 3'd4, 1'b1);
        send_chunk(32'hffffffff, 3'd4, 1'b1);
        send_chunk(32'h80c0e0f0, 3'd5, 1'b1);
        send_chunk(32'h12345678, 3'd6, 1'b1);
        send_chunk(32'hdeadbeef, 3'd7, 1'b1);
        send_chunk(32'h01020304, 3'd0, 1'b0);
        send_chunk(32'hfffefdfc, 3'd1, 1'b0);
        send_chunk(32'h55aa55aa, 3'd2, 1'b0);
        send_chunk(32'haa55aa55, 3'd3, 1'b0);
        send_chunk(32'h9abcdef0, 3'd2, 1'b1);
        send_chunk(32'h00000000, 3'd4, 1'b0);
        send_chunk(32'hffffffff, 3'd4, 1'b1);
    endtask

    task automatic test_seed_extremes();
        write_seed(32'h0);
        send_chunk(32'h0, 3'd0, 1'b1);
        send_chunk(32'h80000001, 3'd4, 1'b1);
        write_seed(32'hffffffff);
        send_chunk(32'h0, 3'd0, 1'b1);
        send_chunk(32'h7ffffffe, 3'd3, 1'b1);
    endtask

    task automatic test_seed_abandons_key();
        send_chunk(32'hcafef00d, 3'd4, 1'b0);
        send_chunk(32'h0badc0de, 3'd4, 1'b0);
        send_chunk(32'h13579bdf, 3'd4, 1'b0);
        write_seed(32'h5a5a5a5a);
        send_chunk(32'h00ff00ff, 3'd4, 1'b1);
    endtask

    task automatic test_output_hold_off();
        no_gaps = 1'b1;
        long_hold <= 1'b1;
        for (int i = 0; i < 40; i++)
            send_chunk($urandom, 3'($urandom_range(0, 4)), 1'b1);
        long_hold <= 1'b0;
        no_gaps = 1'b0;
        wait_quiet();
    endtask

    task automatic test_random_keys();
        logic [31:0] phase_seed;
        int          target;
        int          r;
        for (int p = 0; p < N_PHASES; p++)
        begin
            case (p)
                1: phase_seed = 32'h0;
                2: phase_seed = 32'hffffffff;
                3: phase_seed = mur3_pkg::SEED_RESET;
                default: phase_seed = $urandom;
            endcase
            write_seed(phase_seed);
            target = items_sent + RANDOM_ITEMS / N_PHASES;
            while (items_sent < target)
            begin
                r = $urandom_range(0, 9);
                if (r < 6)
                    send_random_key($urandom_range(0, 3));
                else if (r < 9)
                    send_random_key($urandom_range(4, 12));
                else
                    send_random_key($urandom_range(13, 40));
                if ($urandom_range(0, 39) == 0)
                    wait_quiet();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (hash_expect.size() == 0)
                report_mismatch("unexpected hash", hash, 32'h0);
            else if (hash !== hash_expect[0])
                report_mismatch("hash", hash, hash_expect.pop_front());
            else
                void'(hash_expect.pop_front());
        end
        rx_cycle++;
        if (rx_cycle % 64 == 0)
            rx_mode = $urandom_range(0, 3);
        if (!long_hold)
            hold_count = 0;
        if (long_hold && hold_count < LONG_HOLD)
        begin
            hold_count++;
            out_stall <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                1: out_stall <= ($urandom_range(0, 7) == 0);
                2: out_stall <= ($urandom_range(0, 1) == 0);
                3: out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= 1'b0;
            endcase
        end
    end

    initial
    begin
        #5000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_keys();
        test_seed_extremes();
        test_seed_abandons_key();
        test_output_hold_off();
        test_random_keys();
        wait_quiet();
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
